### design/edh_pkg.sv
// Types, constants and codes shared by the edge de-duplication hash table modules.
`default_nettype none
package edh_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int VERTEX_BITS   = 16;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS     = ADDR_BITS + 1;
   localparam int HASH_SHIFT    = 10;
   localparam int HASH_BITS     = VERTEX_BITS + HASH_SHIFT;
   localparam int TYPE_BITS     = 2;
   localparam int COUNT_BITS    = 8;
   localparam int ACTION_BITS   = 2;
   localparam int STATUS_BITS   = 2;

   // The remainder unit retires two dividend bits per cycle.
   localparam int MOD_RADIX_BITS = 2;
   localparam int MOD_STEPS      = (HASH_BITS + MOD_RADIX_BITS - 1) / MOD_RADIX_BITS;
   localparam int MOD_PAD_BITS   = MOD_STEPS * MOD_RADIX_BITS;
   localparam int MOD_CNT_BITS   = $clog2(MOD_STEPS + 1);

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_LSB  = 2;

   localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(TABLE_DEPTH);
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(TABLE_DEPTH);
   localparam logic [ADDR_BITS-1:0] ADDR_LAST  = ADDR_BITS'(TABLE_DEPTH - 1);

   localparam logic CSR_TABLE_SIZE = 1'b0;

   localparam logic [TYPE_BITS-1:0] ETYPE_FACING = 2'd0;
   localparam logic [TYPE_BITS-1:0] ETYPE_BACK   = 2'd1;
   localparam logic [TYPE_BITS-1:0] ETYPE_UNUSED = 2'd2;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_HASH,
      ST_PROBE,
      ST_RD_ORDER,
      ST_RD_SLOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic [VERTEX_BITS-1:0] lo;
      logic [VERTEX_BITS-1:0] hi;
      logic [TYPE_BITS-1:0]   etype;
      logic [COUNT_BITS-1:0]  facing;
      logic [COUNT_BITS-1:0]  backface;
   } slot_entry_type;

   typedef struct packed {
      status_type             status;
      logic                   was_new;
      logic [ADDR_BITS-1:0]   slot;
      logic [VERTEX_BITS-1:0] lo;
      logic [VERTEX_BITS-1:0] hi;
      logic [TYPE_BITS-1:0]   stype;
      logic [COUNT_BITS-1:0]  facing;
      logic [COUNT_BITS-1:0]  backface;
      logic [SIZE_BITS-1:0]   used_count;
   } result_type;

   typedef struct packed {
      logic                 start;
      logic [HASH_BITS-1:0] dividend;
      logic [SIZE_BITS-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [ADDR_BITS-1:0] remainder;
   } mod_rsp_type;

endpackage
`default_nettype wire

### design/edh_csr.sv
// Configuration register block holding the table size and its clamped effective value.
`default_nettype none
module edh_csr
   import edh_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output logic      [SIZE_BITS-1:0]     eff_size
);

   logic [SIZE_BITS-1:0] table_size_ff;
   logic [SIZE_BITS-1:0] table_size_in;
   logic                 wr_en;
   logic                 reg_index;

   assign reg_index = paddr[CSR_INDEX_LSB];
   assign wr_en     = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      table_size_in = table_size_ff;
      if (wr_en && (reg_index == CSR_TABLE_SIZE)) begin
         table_size_in = pwdata[SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == CSR_TABLE_SIZE) begin
         prdata = {{(CSR_DATA_BITS-SIZE_BITS){1'b0}}, table_size_ff};
      end
   end

   // A size of zero behaves as one slot, and anything above the depth as the full depth.
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = SIZE_BITS'(1);
      end else if (table_size_ff > SIZE_MAX) begin
         eff_size = SIZE_MAX;
      end else begin
         eff_size = table_size_ff;
      end
   end

endmodule
`default_nettype wire

### design/edh_mod_unit.sv
// Iterative remainder unit that reduces the edge hash modulo the table size.
`default_nettype none
module edh_mod_unit
   import edh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type mod_req,
   output mod_rsp_type      mod_rsp
);

   logic                      busy_ff,  busy_in;
   logic                      done_ff,  done_in;
   logic [MOD_CNT_BITS-1:0]   cnt_ff,   cnt_in;
   logic [MOD_PAD_BITS-1:0]   dvd_ff,   dvd_in;
   logic [SIZE_BITS-1:0]      div_ff,   div_in;
   logic [SIZE_BITS-1:0]      rem_ff,   rem_in;
   logic [SIZE_BITS-1:0]      rem_step;

   // Restoring remainder, two bits per cycle; the partial remainder stays below the divisor.
   always_comb begin
      logic [SIZE_BITS:0] trial;
      rem_step = rem_ff;
      for (int i = 0; i < MOD_RADIX_BITS; i++) begin
         trial = {rem_step, dvd_ff[MOD_PAD_BITS-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_step = trial[SIZE_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CNT_BITS'(MOD_STEPS);
         dvd_in  = MOD_PAD_BITS'(mod_req.dividend);
         div_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << MOD_RADIX_BITS;
         cnt_in = cnt_ff - MOD_CNT_BITS'(1);
         if (cnt_ff == MOD_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff[ADDR_BITS-1:0];

endmodule
`default_nettype wire

### design/edh_engine.sv
// Sequencer with the slot memory and used-list memory: probe, update, clear and read.
`default_nettype none
module edh_engine
   import edh_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [SIZE_BITS-1:0]   eff_size,
   output mod_req_type                 mod_req,
   input  wire mod_rsp_type            mod_rsp,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ACTION_BITS-1:0] req_action,
   input  wire logic [VERTEX_BITS-1:0] req_vertex_a,
   input  wire logic [VERTEX_BITS-1:0] req_vertex_b,
   input  wire logic [TYPE_BITS-1:0]   req_edge_type,
   input  wire logic [ADDR_BITS-1:0]   req_read_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output result_type                  rsp_result
);

   state_type              state_ff,      state_in;
   logic [VERTEX_BITS-1:0] lo_ff,         lo_in;
   logic [VERTEX_BITS-1:0] hi_ff,         hi_in;
   logic [TYPE_BITS-1:0]   etype_ff,      etype_in;
   logic [ADDR_BITS-1:0]   cur_ff,        cur_in;
   logic [SIZE_BITS-1:0]   probe_cnt_ff,  probe_cnt_in;
   logic [ADDR_BITS-1:0]   sweep_ff,      sweep_in;
   logic [SIZE_BITS-1:0]   used_total_ff, used_total_in;
   result_type             res_ff,        res_in;
   result_type             rsp_ff,        rsp_in;
   logic                   rsp_valid_ff,  rsp_valid_in;

   slot_entry_type         slot_mem [TABLE_DEPTH];
   slot_entry_type         slot_rd_ff;
   logic [ADDR_BITS-1:0]   slot_rd_addr;
   logic                   slot_we;
   logic [ADDR_BITS-1:0]   slot_wr_addr;
   slot_entry_type         slot_wr_data;

   logic [ADDR_BITS-1:0]   order_mem [TABLE_DEPTH];
   logic [ADDR_BITS-1:0]   order_rd_ff;
   logic                   order_we;

   logic                   req_accept;
   logic                   out_free;
   logic [VERTEX_BITS-1:0] req_lo;
   logic [VERTEX_BITS-1:0] req_hi;
   logic [TYPE_BITS-1:0]   req_etype;
   logic                   hit;
   logic                   list_full;
   logic [ADDR_BITS-1:0]   next_cur;
   slot_entry_type         upd;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      slot_rd_ff <= slot_mem[slot_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[used_total_ff[ADDR_BITS-1:0]] <= cur_ff;
      end
      order_rd_ff <= order_mem[req_read_index];
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_lo    = (req_vertex_a < req_vertex_b) ? req_vertex_a : req_vertex_b;
   assign req_hi    = (req_vertex_a < req_vertex_b) ? req_vertex_b : req_vertex_a;
   assign req_etype = (req_edge_type > ETYPE_UNUSED) ? ETYPE_UNUSED : req_edge_type;

   assign hit       = slot_rd_ff.valid && (slot_rd_ff.lo == lo_ff) && (slot_rd_ff.hi == hi_ff);
   assign list_full = used_total_ff[ADDR_BITS];
   assign next_cur  = (({1'b0, cur_ff} + SIZE_BITS'(1)) == eff_size) ? '0
                                                                     : cur_ff + ADDR_BITS'(1);

   // An empty slot reads as all zeros, so a new edge starts from zero counts.
   always_comb begin
      upd       = slot_rd_ff;
      upd.valid = 1'b1;
      upd.lo    = lo_ff;
      upd.hi    = hi_ff;
      if (!slot_rd_ff.valid || (slot_rd_ff.etype > etype_ff)) begin
         upd.etype = etype_ff;
      end
      upd.facing   = slot_rd_ff.facing + COUNT_BITS'(etype_ff == ETYPE_FACING);
      upd.backface = slot_rd_ff.backface + COUNT_BITS'(etype_ff == ETYPE_BACK);
   end

   always_comb begin
      state_in         = state_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      etype_in         = etype_ff;
      cur_in           = cur_ff;
      probe_cnt_in     = probe_cnt_ff;
      sweep_in         = sweep_ff;
      used_total_in    = used_total_ff;
      res_in           = res_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      slot_rd_addr     = cur_ff;
      slot_we          = 1'b0;
      slot_wr_addr     = cur_ff;
      slot_wr_data     = upd;
      order_we         = 1'b0;
      mod_req.start    = 1'b0;
      mod_req.dividend = HASH_BITS'(req_lo) ^ {req_hi, {HASH_SHIFT{1'b0}}};
      mod_req.divisor  = eff_size;

      unique case (state_ff)
         ST_INIT: begin
            // Clearing pass over the whole slot memory after reset.
            slot_we      = 1'b1;
            slot_wr_addr = sweep_ff;
            slot_wr_data = '0;
            sweep_in     = sweep_ff + ADDR_BITS'(1);
            if (sweep_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               lo_in    = req_lo;
               hi_in    = req_hi;
               etype_in = req_etype;
               res_in            = '0;
               res_in.used_count = used_total_ff;
               unique case (action_type'(req_action))
                  ACT_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_ADD: begin
                     mod_req.start = 1'b1;
                     state_in      = ST_HASH;
                  end
                  ACT_READ: begin
                     if ({1'b0, req_read_index} < used_total_ff) begin
                        state_in = ST_RD_ORDER;
                     end else begin
                        res_in.status = STATUS_RANGE;
                        state_in      = ST_FINISH;
                     end
                  end
                  ACT_NONE: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            slot_we      = 1'b1;
            slot_wr_addr = sweep_ff;
            slot_wr_data = '0;
            sweep_in     = sweep_ff + ADDR_BITS'(1);
            if (({1'b0, sweep_ff} + SIZE_BITS'(1)) == eff_size) begin
               sweep_in      = '0;
               used_total_in = '0;
               res_in        = '0;
               state_in      = ST_FINISH;
            end
         end
         ST_HASH: begin
            if (mod_rsp.done) begin
               cur_in       = mod_rsp.remainder;
               probe_cnt_in = '0;
               slot_rd_addr = mod_rsp.remainder;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            res_in            = '0;
            res_in.used_count = used_total_ff;
            if (hit || (!slot_rd_ff.valid && !list_full)) begin
               slot_we         = 1'b1;
               res_in.status   = STATUS_OK;
               res_in.was_new  = !hit;
               res_in.slot     = cur_ff;
               res_in.lo       = upd.lo;
               res_in.hi       = upd.hi;
               res_in.stype    = upd.etype;
               res_in.facing   = upd.facing;
               res_in.backface = upd.backface;
               if (!hit) begin
                  order_we          = 1'b1;
                  used_total_in     = used_total_ff + SIZE_BITS'(1);
                  res_in.used_count = used_total_in;
               end
               state_in = ST_FINISH;
            end else if (!slot_rd_ff.valid ||
                         ((probe_cnt_ff + SIZE_BITS'(1)) == eff_size)) begin
               // Every slot in use was visited, or the used list has no room.
               res_in.status = STATUS_FULL;
               res_in.lo     = lo_ff;
               res_in.hi     = hi_ff;
               state_in      = ST_FINISH;
            end else begin
               cur_in       = next_cur;
               probe_cnt_in = probe_cnt_ff + SIZE_BITS'(1);
               slot_rd_addr = next_cur;
            end
         end
         ST_RD_ORDER: begin
            cur_in       = order_rd_ff;
            slot_rd_addr = order_rd_ff;
            state_in     = ST_RD_SLOT;
         end
         ST_RD_SLOT: begin
            res_in            = '0;
            res_in.status     = STATUS_OK;
            res_in.slot       = cur_ff;
            res_in.lo         = slot_rd_ff.lo;
            res_in.hi         = slot_rd_ff.hi;
            res_in.stype      = slot_rd_ff.etype;
            res_in.facing     = slot_rd_ff.facing;
            res_in.backface   = slot_rd_ff.backface;
            res_in.used_count = used_total_ff;
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         used_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      etype_ff     <= etype_in;
      cur_ff       <= cur_in;
      probe_cnt_ff <= probe_cnt_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule
`default_nettype wire

### design/edge_dedup_hash_table_core.sv
// Edge de-duplication hash table: one item in flight at a time, one transfer out per item.
// Add: the remainder unit yields the home slot, then slots are probed, one per cycle,
//   through the single slot-memory port.
// Read: used-list memory read, then slot memory read; an index out of range skips both.
// Clear: sweeps the first effective table_size slots to empty. A stalled result holds the next item back.
// After reset, req_stall stays high while the whole slot memory is swept to empty.
`default_nettype none
module edge_dedup_hash_table_core
   import edh_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ACTION_BITS-1:0]   req_action,
   input  wire logic [VERTEX_BITS-1:0]   req_vertex_a,
   input  wire logic [VERTEX_BITS-1:0]   req_vertex_b,
   input  wire logic [TYPE_BITS-1:0]     req_edge_type,
   input  wire logic [ADDR_BITS-1:0]     req_read_index,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [STATUS_BITS-1:0]   rsp_status,
   output logic                          rsp_was_new,
   output logic      [ADDR_BITS-1:0]     rsp_slot,
   output logic      [VERTEX_BITS-1:0]   rsp_low_vertex,
   output logic      [VERTEX_BITS-1:0]   rsp_high_vertex,
   output logic      [TYPE_BITS-1:0]     rsp_stored_type,
   output logic      [COUNT_BITS-1:0]    rsp_facing_count,
   output logic      [COUNT_BITS-1:0]    rsp_back_count,
   output logic      [SIZE_BITS-1:0]     rsp_used_count,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   logic [SIZE_BITS-1:0] eff_size;
   mod_req_type          mod_req;
   mod_rsp_type          mod_rsp;
   result_type           rsp_result;

   edh_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .eff_size (eff_size)
   );

   edh_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   edh_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .eff_size       (eff_size),
      .mod_req        (mod_req),
      .mod_rsp        (mod_rsp),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .req_edge_type  (req_edge_type),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result     (rsp_result)
   );

   assign rsp_status       = rsp_result.status;
   assign rsp_was_new      = rsp_result.was_new;
   assign rsp_slot         = rsp_result.slot;
   assign rsp_low_vertex   = rsp_result.lo;
   assign rsp_high_vertex  = rsp_result.hi;
   assign rsp_stored_type  = rsp_result.stype;
   assign rsp_facing_count = rsp_result.facing;
   assign rsp_back_count   = rsp_result.backface;
   assign rsp_used_count   = rsp_result.used_count;

endmodule
`default_nettype wire

### design/edh_checker.sv
// Port-level checker for the edge de-duplication hash table, bound to the top level.
`default_nettype none
module edh_checker
   import edh_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [STATUS_BITS-1:0] rsp_status,
   input wire logic [ADDR_BITS-1:0]   rsp_slot,
   input wire logic [SIZE_BITS-1:0]   rsp_used_count
);

   // A stalled result transfer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
                                 && $stable(rsp_used_count))
      else $error("result changed while stalled");

   // Only one item is worked on at a time, so an input transfer closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item was in flight");

   // The slot memory sweep holds off input and results right after reset.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not held off after reset");

   // A new result is only staged from a busy sequencer.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

endmodule

bind edge_dedup_hash_table_core edh_checker u_edh_checker (.*);
`default_nettype wire
